@@ src/ogrw_pkg.sv @@
// shared types and constants of the outlined glyph row writer
`default_nettype none
package ogrw_pkg;

	// glyph geometry
	localparam int GLYPH_SIZE = 8;
	localparam int BOX_W = GLYPH_SIZE + 2;
	localparam int ROW_CNT_W = $clog2(BOX_W);
	localparam int GLYPH_ROW_W = $clog2(GLYPH_SIZE);

	// coordinate and frame widths
	localparam int COORD_W = 14;
	localparam int OUT_COORD_W = 15;
	localparam int CALC_W = 16;
	localparam int DIM_W = 13;
	localparam int COLOR_W = 32;
	localparam int GLYPH_W = 64;
	localparam int CODE_W = 8;

	localparam logic [DIM_W-1:0] MAX_FRAME_DIM = 13'd4096;
	localparam logic signed [OUT_COORD_W-1:0] COORD_MAX = 15'sd8191;
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_TEXT_COLOR    = 3'd2,
		REG_OUTLINE_COLOR = 3'd3
	} cfg_reg_t;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 32'hFFFF_FFFF;
	localparam logic [COLOR_W-1:0] OUTLINE_COLOR_RST = 32'h0000_0000;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic [BOX_W-1:0]          col_on;
		logic [GLYPH_W-1:0]        glyph;
	} char_entry_t;

endpackage
`default_nettype wire

@@ src/ogrw_front.sv @@
// front end: takes characters, keeps the cursor and queues drawn characters
`default_nettype none
module ogrw_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic                                new_string,
	input  wire logic signed [ogrw_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [ogrw_pkg::COORD_W-1:0] start_y,
	input  wire logic [ogrw_pkg::CODE_W-1:0]         char_code,
	input  wire logic [ogrw_pkg::GLYPH_W-1:0]        glyph_bits,
	input  wire logic [ogrw_pkg::DIM_W-1:0]          clip_width,
	output      logic                                q_push,
	output      ogrw_pkg::char_entry_t               q_data
);
	import ogrw_pkg::*;

	logic signed [COORD_W-1:0] origin_q, col_q, row_q;
	logic signed [COORD_W-1:0] eff_origin, eff_col, eff_row;
	logic signed [COORD_W-1:0] col_next, row_next;
	logic                      is_newline;
	logic [BOX_W-1:0]          col_on;
	logic [CALC_W-1:0]         xx;

	// saturating advance by one glyph
	function automatic logic signed [COORD_W-1:0] sat_adv(logic signed [COORD_W-1:0] v);
		logic signed [OUT_COORD_W-1:0] s;
		s = OUT_COORD_W'(v) + OUT_COORD_W'(GLYPH_SIZE);
		return (s > COORD_MAX) ? COORD_W'(COORD_MAX) : s[COORD_W-1:0];
	endfunction

	// coordinates after an optional string load
	always_comb begin
		eff_origin = new_string ? start_x : origin_q;
		eff_col    = new_string ? start_x : col_q;
		eff_row    = new_string ? start_y : row_q;
		is_newline = (char_code == NEWLINE_CODE);
		col_next   = is_newline ? eff_origin : sat_adv(eff_col);
		row_next   = is_newline ? sat_adv(eff_row) : eff_row;
	end

	// horizontal clipping of the ten box columns
	always_comb begin
		xx = '0;
		for (int i = 0; i < BOX_W; i++) begin
			xx = CALC_W'(eff_col) - CALC_W'(1) + CALC_W'(i);
			col_on[i] = !xx[CALC_W-1] && (xx < CALC_W'(clip_width));
		end
	end

	// queue word
	always_comb begin
		q_push        = accept && !is_newline;
		q_data.col    = eff_col;
		q_data.row    = eff_row;
		q_data.col_on = col_on;
		q_data.glyph  = glyph_bits;
	end

	// cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (accept) begin
			origin_q <= eff_origin;
			col_q    <= col_next;
			row_q    <= row_next;
		end
	end

endmodule
`default_nettype wire

@@ src/ogrw_queue.sv @@
// short register queue between front and back
`default_nettype none
module ogrw_queue #(
	parameter int DEPTH = ogrw_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ogrw_pkg::char_entry_t push_data,
	output      logic                  full,
	input  wire logic                  pop,
	output      logic                  empty,
	output      ogrw_pkg::char_entry_t pop_data
);
	import ogrw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	char_entry_t    mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

@@ src/ogrw_back.sv @@
// back end: walks the ten rows of a character and builds the pixel masks
`default_nettype none
module ogrw_back (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    q_empty,
	input  wire ogrw_pkg::char_entry_t                   q_data,
	output      logic                                    q_pop,
	input  wire logic [ogrw_pkg::DIM_W-1:0]              clip_height,
	input  wire logic [ogrw_pkg::COLOR_W-1:0]            text_color,
	input  wire logic [ogrw_pkg::COLOR_W-1:0]            outline_color,
	input  wire logic                                    pop,
	output      logic                                    empty,
	output      logic signed [ogrw_pkg::OUT_COORD_W-1:0] row_y,
	output      logic signed [ogrw_pkg::OUT_COORD_W-1:0] row_x_start,
	output      logic [ogrw_pkg::BOX_W-1:0]              pixel_mask,
	output      logic [ogrw_pkg::BOX_W-1:0]              pixel_is_text,
	output      logic [ogrw_pkg::COLOR_W-1:0]            text_color_out,
	output      logic [ogrw_pkg::COLOR_W-1:0]            outline_color_out,
	output      logic                                    last_row
);
	import ogrw_pkg::*;

	char_entry_t           cur_q;
	logic                  busy_q;
	logic [ROW_CNT_W-1:0]  k_q;
	logic                  ov_q;
	logic                  adv, at_last, load;

	logic [CALC_W-1:0]     yy [3];
	logic signed [4:0]     gr [3];
	logic [2:0]            row_on;
	logic [BOX_W-1:0]      rbits [3];
	logic [BOX_W-1:0]      gon [3];
	logic [BOX_W-1:0]      hit, pix_on, mask_c, txt_c;

	assign at_last = (k_q == ROW_CNT_W'(BOX_W - 1));
	assign adv     = busy_q && (!ov_q || pop);
	assign load    = (!busy_q || (adv && at_last)) && !q_empty;
	assign q_pop   = load;
	assign empty   = !ov_q;

	// glyph rows and vertical clipping around the current row
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			yy[d] = CALC_W'(cur_q.row) + CALC_W'(k_q) - CALC_W'(2) + CALC_W'(d);
			row_on[d] = !yy[d][CALC_W-1] && (yy[d] < CALC_W'(clip_height));
			gr[d] = $signed({1'b0, 4'(k_q)}) - 5'sd2 + 5'(d);
			if (gr[d] >= 5'sd0 && gr[d] < 5'(GLYPH_SIZE)) begin
				rbits[d] = {1'b0,
					cur_q.glyph[{gr[d][GLYPH_ROW_W-1:0], GLYPH_ROW_W'(0)} +: GLYPH_SIZE],
					1'b0};
			end else begin
				rbits[d] = '0;
			end
			gon[d] = rbits[d] & cur_q.col_on & {BOX_W{row_on[d]}};
		end
	end

	// text and outline masks for the row
	always_comb begin
		hit = '0;
		for (int d = 0; d < 3; d++) begin
			hit = hit | gon[d] | (gon[d] << 1) | (gon[d] >> 1);
		end
		pix_on = cur_q.col_on & {BOX_W{row_on[1]}};
		txt_c  = pix_on & rbits[1];
		mask_c = pix_on & (rbits[1] | hit);
	end

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			k_q    <= '0;
		end else if (adv) begin
			if (at_last) begin
				busy_q <= 1'b0;
				k_q    <= '0;
			end else begin
				k_q <= k_q + ROW_CNT_W'(1);
			end
		end
	end

	// character being drawn
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (adv) begin
			row_y             <= OUT_COORD_W'(cur_q.row) - OUT_COORD_W'(1)
				+ OUT_COORD_W'(k_q);
			row_x_start       <= OUT_COORD_W'(cur_q.col) - OUT_COORD_W'(1);
			pixel_mask        <= mask_c;
			pixel_is_text     <= txt_c;
			text_color_out    <= text_color;
			outline_color_out <= outline_color;
			last_row          <= at_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q < ROW_CNT_W'(BOX_W))
		else $error("row counter beyond box");
	a_idle_k: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (k_q == '0))
		else $error("row counter not cleared while idle");
	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(busy_q))
		else $error("output word without a character in progress");
	a_load_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !at_last) |-> !load)
		else $error("new character loaded mid box");
`endif

endmodule
`default_nettype wire

@@ src/outlined_glyph_row_writer.sv @@
// top level of the outlined glyph row writer: configuration and block wiring
//
// Each input word is one character with its 8x8 glyph. A newline only moves
// the cursor and gives no output; any other character gives ten row writes,
// one per cycle while pop keeps taking them, covering the glyph box plus a
// one-pixel border, with the last one flagged by last_row. The back end walks
// one box row per cycle unless the output word is waiting to be popped, and
// takes the next character as it leaves the last row; the front end takes a
// word every cycle while the two-entry queue in front of the row walker has
// room, so newlines are hidden behind drawing. Configuration (frame size and
// colours) is written through cfg_we/cfg_index/cfg_data and takes effect on
// the next character; write it only while the block is idle.
`default_nettype none
module outlined_glyph_row_writer #(
	parameter int QDEPTH = ogrw_pkg::QUEUE_DEPTH
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [ogrw_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [ogrw_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                                    push,
	output      logic                                    full,
	input  wire logic                                    new_string,
	input  wire logic signed [ogrw_pkg::COORD_W-1:0]     start_x,
	input  wire logic signed [ogrw_pkg::COORD_W-1:0]     start_y,
	input  wire logic [ogrw_pkg::CODE_W-1:0]             char_code,
	input  wire logic [ogrw_pkg::GLYPH_W-1:0]            glyph_bits,
	output      logic                                    empty,
	input  wire logic                                    pop,
	output      logic signed [ogrw_pkg::OUT_COORD_W-1:0] row_y,
	output      logic signed [ogrw_pkg::OUT_COORD_W-1:0] row_x_start,
	output      logic [ogrw_pkg::BOX_W-1:0]              pixel_mask,
	output      logic [ogrw_pkg::BOX_W-1:0]              pixel_is_text,
	output      logic [ogrw_pkg::COLOR_W-1:0]            text_color_out,
	output      logic [ogrw_pkg::COLOR_W-1:0]            outline_color_out,
	output      logic                                    last_row
);
	import ogrw_pkg::*;

	logic [DIM_W-1:0]   frame_width_q, frame_height_q;
	logic [COLOR_W-1:0] text_color_q, outline_color_q;
	logic [DIM_W-1:0]   clip_width, clip_height;
	logic               accept;
	logic               q_push, q_full, q_pop, q_empty;
	char_entry_t        q_wdata, q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= FRAME_WIDTH_RST;
			frame_height_q  <= FRAME_HEIGHT_RST;
			text_color_q    <= TEXT_COLOR_RST;
			outline_color_q <= OUTLINE_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[DIM_W-1:0];
				REG_TEXT_COLOR:    text_color_q    <= cfg_data[COLOR_W-1:0];
				REG_OUTLINE_COLOR: outline_color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// frame size limited to the largest supported frame
	assign clip_width  = (frame_width_q > MAX_FRAME_DIM) ? MAX_FRAME_DIM : frame_width_q;
	assign clip_height = (frame_height_q > MAX_FRAME_DIM) ? MAX_FRAME_DIM : frame_height_q;

	assign full   = q_full;
	assign accept = push && !q_full;

	// front end
	ogrw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.new_string (new_string),
		.start_x    (start_x),
		.start_y    (start_y),
		.char_code  (char_code),
		.glyph_bits (glyph_bits),
		.clip_width (clip_width),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	// character queue
	ogrw_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_rdata)
	);

	// row walker
	ogrw_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_empty           (q_empty),
		.q_data            (q_rdata),
		.q_pop             (q_pop),
		.clip_height       (clip_height),
		.text_color        (text_color_q),
		.outline_color     (outline_color_q),
		.pop               (pop),
		.empty             (empty),
		.row_y             (row_y),
		.row_x_start       (row_x_start),
		.pixel_mask        (pixel_mask),
		.pixel_is_text     (pixel_is_text),
		.text_color_out    (text_color_out),
		.outline_color_out (outline_color_out),
		.last_row          (last_row)
	);

endmodule
`default_nettype wire
